FILE: hw/rtl/pqcu_pkg.sv
// Shared types and codes for the pending queue with cancel and undo.
// No dependencies; the top module and the checker import this package.
package pqcu_pkg;

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int IO_ID_W  = 16;
  localparam int CNT_W    = 5;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t FUNC_ADD      = 2'd0;
  localparam func_t FUNC_COMPLETE = 2'd1;
  localparam func_t FUNC_UNDO     = 2'd2;
  localparam func_t FUNC_CANCEL   = 2'd3;

  localparam status_t STATUS_OK   = 2'd0;
  localparam status_t STATUS_MISS = 2'd1;
  localparam status_t STATUS_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_C_WR,
    ST_U_WR,
    ST_X_RD,
    ST_X_CMP,
    ST_X_SRD,
    ST_X_SWR,
    ST_FIN
  } state_t;

endpackage

FILE: hw/rtl/pending_queue_with_cancel_and_undo.sv
// Pending queue with cancel by id and undo history; uses pqcu_pkg, pqcu_ram.
// An add or an early status goes from idle straight to the finish state; complete
// passes through ST_C_WR and undo through ST_U_WR; cancel reads and compares each
// entry up to the match (all on a miss), then reads and rewrites each later entry.
// One command at a time, taken only in idle; the next is taken while a result
// waits. Synchronous active-low reset empties queue and history; no clearing pass.
module pending_queue_with_cancel_and_undo #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int HISTORY_DEPTH = 16,
  parameter int ID_BITS       = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pqcu_pkg::func_t            in_func,
  input  logic [pqcu_pkg::IO_ID_W-1:0] in_order_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pqcu_pkg::status_t          out_status,
  output logic [pqcu_pkg::IO_ID_W-1:0] out_result_id,
  output logic [pqcu_pkg::CNT_W-1:0]   out_pending_count
);
  import pqcu_pkg::*;

  // Pointer and fill widths; fills must hold the depth itself.
  localparam int QA  = $clog2(QUEUE_DEPTH);
  localparam int QFW = $clog2(QUEUE_DEPTH + 1);
  localparam int HA  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HFW = $clog2(HISTORY_DEPTH + 1);

  state_t state_r, state_nxt;

  // Queue is a ring: head pointer plus fill. History is a ring too, so a
  // push on a full history just overwrites the oldest slot and moves base.
  logic [QA-1:0]      q_head_r, q_head_nxt;
  logic [QFW-1:0]     q_fill_r, q_fill_nxt;
  logic [HA-1:0]      h_base_r, h_base_nxt;
  logic [HFW-1:0]     h_fill_r, h_fill_nxt;
  logic [QFW-1:0]     idx_r, idx_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [ID_BITS-1:0] res_id_r, res_id_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [IO_ID_W-1:0] out_result_id_r, out_result_id_nxt;
  logic [CNT_W-1:0]   out_pending_count_r, out_pending_count_nxt;

  // Shared queue address unit: head plus offset, folded back into range.
  logic [QFW-1:0]     q_off;
  logic [QFW:0]       q_sum;
  logic [QA-1:0]      q_addr;
  logic               q_we;
  logic [ID_BITS-1:0] q_wdata;
  logic [ID_BITS-1:0] q_rdata;

  logic [HFW-1:0]     h_off;
  logic [HFW:0]       h_sum;
  logic [HA-1:0]      h_addr;
  logic [HA:0]        h_inc_sum;
  logic [HA-1:0]      h_inc;
  logic               h_we;
  logic [ID_BITS-1:0] h_rdata;

  logic [31:0]        in_id_wide;
  logic [ID_BITS-1:0] in_id;
  logic [31:0]        res_id_wide;
  logic [QFW:0]       idx_p1;
  logic [QFW:0]       idx_p2;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_id_wide = 32'(in_order_id);
  assign in_id      = in_id_wide[ID_BITS-1:0];
  assign idx_p1     = (QFW+1)'(idx_r) + (QFW+1)'(1);
  assign idx_p2     = (QFW+1)'(idx_r) + (QFW+1)'(2);

  always_comb begin
    q_sum  = (QFW+1)'(q_head_r) + (QFW+1)'(q_off);
    q_addr = (q_sum >= (QFW+1)'(QUEUE_DEPTH)) ?
             QA'(q_sum - (QFW+1)'(QUEUE_DEPTH)) : QA'(q_sum);
    h_sum  = (HFW+1)'(h_base_r) + (HFW+1)'(h_off);
    h_addr = (h_sum >= (HFW+1)'(HISTORY_DEPTH)) ?
             HA'(h_sum - (HFW+1)'(HISTORY_DEPTH)) : HA'(h_sum);
    h_inc_sum = (HA+1)'(h_base_r) + (HA+1)'(1);
    h_inc  = (h_inc_sum >= (HA+1)'(HISTORY_DEPTH)) ? '0 : HA'(h_inc_sum);
  end

  pqcu_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_BITS),
    .AW    (QA)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_addr),
    .wdata (q_wdata),
    .raddr (q_addr),
    .rdata (q_rdata)
  );

  pqcu_ram #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (ID_BITS),
    .AW    (HA)
  ) u_history_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_addr),
    .wdata (q_rdata),
    .raddr (h_addr),
    .rdata (h_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      q_head_r    <= '0;
      q_fill_r    <= '0;
      h_base_r    <= '0;
      h_fill_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      q_head_r    <= q_head_nxt;
      q_fill_r    <= q_fill_nxt;
      h_base_r    <= h_base_nxt;
      h_fill_r    <= h_fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r               <= idx_nxt;
    id_r                <= id_nxt;
    res_status_r        <= res_status_nxt;
    res_id_r            <= res_id_nxt;
    out_status_r        <= out_status_nxt;
    out_result_id_r     <= out_result_id_nxt;
    out_pending_count_r <= out_pending_count_nxt;
  end

  assign res_id_wide = 32'(res_id_r);

  always_comb begin
    state_nxt             = state_r;
    q_head_nxt            = q_head_r;
    q_fill_nxt            = q_fill_r;
    h_base_nxt            = h_base_r;
    h_fill_nxt            = h_fill_r;
    idx_nxt               = idx_r;
    id_nxt                = id_r;
    res_status_nxt        = res_status_r;
    res_id_nxt            = res_id_r;
    out_valid_nxt         = out_valid_r;
    out_status_nxt        = out_status_r;
    out_result_id_nxt     = out_result_id_r;
    out_pending_count_nxt = out_pending_count_r;
    q_off                 = '0;
    q_we                  = 1'b0;
    q_wdata               = q_rdata;
    h_off                 = h_fill_r;
    h_we                  = 1'b0;

    // Drop the result once the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          id_nxt         = in_id;
          res_id_nxt     = '0;
          res_status_nxt = STATUS_OK;
          idx_nxt        = '0;
          state_nxt      = ST_FIN;
          case (in_func)
            FUNC_ADD: begin
              if (q_fill_r == QFW'(QUEUE_DEPTH)) begin
                res_status_nxt = STATUS_FULL;
              end else begin
                // Append at the tail.
                q_off      = q_fill_r;
                q_we       = 1'b1;
                q_wdata    = in_id;
                q_fill_nxt = q_fill_r + QFW'(1);
                res_id_nxt = in_id;
              end
            end
            FUNC_COMPLETE: begin
              if (q_fill_r == '0) begin
                res_status_nxt = STATUS_MISS;
              end else begin
                q_off     = '0;
                state_nxt = ST_C_WR;
              end
            end
            FUNC_UNDO: begin
              if (h_fill_r == '0) begin
                res_status_nxt = STATUS_MISS;
              end else if (q_fill_r == QFW'(QUEUE_DEPTH)) begin
                res_status_nxt = STATUS_FULL;
              end else begin
                // Read the newest history entry.
                h_off      = h_fill_r - HFW'(1);
                h_fill_nxt = h_fill_r - HFW'(1);
                state_nxt  = ST_U_WR;
              end
            end
            FUNC_CANCEL: begin
              if (q_fill_r == '0) begin
                res_status_nxt = STATUS_MISS;
              end else begin
                q_off     = '0;
                state_nxt = ST_X_CMP;
              end
            end
            default: begin
              res_status_nxt = STATUS_MISS;
            end
          endcase
        end
      end

      ST_C_WR: begin
        // Push the old head onto history; a full history loses its oldest.
        h_we = 1'b1;
        if (h_fill_r == HFW'(HISTORY_DEPTH)) begin
          h_off      = '0;
          h_base_nxt = h_inc;
        end else begin
          h_off      = h_fill_r;
          h_fill_nxt = h_fill_r + HFW'(1);
        end
        q_off      = QFW'(1);
        q_head_nxt = q_addr;
        q_fill_nxt = q_fill_r - QFW'(1);
        res_id_nxt = q_rdata;
        state_nxt  = ST_FIN;
      end

      ST_U_WR: begin
        // Put the restored id in front of the head.
        q_off      = QFW'(QUEUE_DEPTH - 1);
        q_we       = 1'b1;
        q_wdata    = h_rdata;
        q_head_nxt = q_addr;
        q_fill_nxt = q_fill_r + QFW'(1);
        res_id_nxt = h_rdata;
        state_nxt  = ST_FIN;
      end

      ST_X_RD: begin
        q_off     = idx_r;
        state_nxt = ST_X_CMP;
      end

      ST_X_CMP: begin
        if (q_rdata == id_r) begin
          res_id_nxt = id_r;
          if (idx_p1 < (QFW+1)'(q_fill_r)) begin
            state_nxt = ST_X_SRD;
          end else begin
            q_fill_nxt = q_fill_r - QFW'(1);
            state_nxt  = ST_FIN;
          end
        end else if (idx_p1 >= (QFW+1)'(q_fill_r)) begin
          res_status_nxt = STATUS_MISS;
          state_nxt      = ST_FIN;
        end else begin
          idx_nxt   = QFW'(idx_p1);
          state_nxt = ST_X_RD;
        end
      end

      ST_X_SRD: begin
        // Close the gap: fetch the entry behind the hole.
        q_off     = QFW'(idx_p1);
        state_nxt = ST_X_SWR;
      end

      ST_X_SWR: begin
        q_off   = idx_r;
        q_we    = 1'b1;
        q_wdata = q_rdata;
        if (idx_p2 >= (QFW+1)'(q_fill_r)) begin
          q_fill_nxt = q_fill_r - QFW'(1);
          state_nxt  = ST_FIN;
        end else begin
          idx_nxt   = QFW'(idx_p1);
          state_nxt = ST_X_SRD;
        end
      end

      ST_FIN: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_status_nxt        = res_status_r;
          out_result_id_nxt     = (res_status_r == STATUS_OK) ?
                                  res_id_wide[IO_ID_W-1:0] : '0;
          out_pending_count_nxt = CNT_W'(q_fill_r);
          state_nxt             = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_id     = out_result_id_r;
  assign out_pending_count = out_pending_count_r;

endmodule

FILE: hw/rtl/pqcu_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing; holds the queue and history entries.
module pqcu_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/pqcu_checker.sv
// Port-level checks for the pending queue; uses pqcu_pkg.
// Bound to pending_queue_with_cancel_and_undo at the end of this file.
module pqcu_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input pqcu_pkg::status_t            out_status,
  input logic [pqcu_pkg::IO_ID_W-1:0] out_result_id,
  input logic [pqcu_pkg::CNT_W-1:0]   out_pending_count
);
  import pqcu_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_result_id) && $stable(out_pending_count))
    else $error("stalled result changed");

  // The block is not ready right after it accepts a command.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted transaction");

  // Failed commands carry a zero id.
  a_fail_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> out_result_id == '0)
    else $error("nonzero id on a failed command");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_MISS ||
                   out_status == STATUS_FULL))
    else $error("undefined status code");

endmodule

bind pending_queue_with_cancel_and_undo pqcu_checker u_pqcu_checker (.*);
